// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation codes, error codes, field widths and the default operand width.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

   // Field widths fixed by the interface.
   localparam int MODE_W    = 3;
   localparam int ERR_W     = 2;
   localparam int NUM_OUT_W = 33;
   localparam int DEN_OUT_W = 31;

   // Default operand width.
   localparam int DEFAULT_OPERAND_WIDTH = 16;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REDUCE = 3'd4;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front: request classifier
// Folds unused modes onto reduce, checks for invalid operands and packs one
// queue entry per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_front
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH,
   localparam int ENTRY_W = ERR_W + MODE_W + 4 * OPERAND_WIDTH
) (
   input  wire logic [MODE_W-1:0]        mode,
   input  wire logic [OPERAND_WIDTH-1:0] num_a,
   input  wire logic [OPERAND_WIDTH-1:0] den_a,
   input  wire logic [OPERAND_WIDTH-1:0] num_b,
   input  wire logic [OPERAND_WIDTH-1:0] den_b,
   output logic      [ENTRY_W-1:0]       entry
);

   logic [MODE_W-1:0] mode_c;
   logic [ERR_W-1:0]  err_c;

   // Classify the operation and flag invalid operands.
   always_comb begin
      mode_c = (mode > MODE_REDUCE) ? MODE_REDUCE : mode;
      err_c  = ERR_OK;
      if (den_a == '0) begin
         err_c = ERR_ZERO_DEN;
      end else if (mode_c != MODE_REDUCE && den_b == '0) begin
         err_c = ERR_ZERO_DEN;
      end else if (mode_c == MODE_DIV && num_b == '0) begin
         err_c = ERR_DIV_ZERO;
      end
   end

   assign entry = {err_c, mode_c, num_a, den_a, num_b, den_b};

endmodule

`default_nettype wire

// ===== rtl/core/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue: two-entry queue between front and back end
// Lets the request side keep accepting while the back end is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_queue
   import rau_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output queue_ctl_type         ctl_out,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full          = (count_ff == 2'd2);
   assign ctl_out.valid = (count_ff != 2'd0);
   assign ctl_out.pop   = pop;
   assign pop_data      = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/core/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back: fraction arithmetic and reduction engine
// Forms cross products with one shared multiplier, finds the GCD with a
// binary GCD loop and divides both magnitudes by it with a shift-subtract
// divider, then holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_back
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH,
   localparam int ENTRY_W = ERR_W + MODE_W + 4 * OPERAND_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire queue_ctl_type        q_ctl,
   input  wire logic [ENTRY_W-1:0]   q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [NUM_OUT_W-1:0] rsp_result_num,
   output logic      [DEN_OUT_W-1:0] rsp_result_den,
   output logic      [ERR_W-1:0]     rsp_error
);

   localparam int OW = OPERAND_WIDTH;
   localparam int NW = 2 * OW + 1;
   localparam int MW = 2 * OW;
   localparam int KW = $clog2(MW + 1);
   localparam int XW = (MW + 1 > NUM_OUT_W) ? MW + 1 : NUM_OUT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_GCD  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic signed [OW-1:0] na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;
   logic signed [NW-1:0] n_ff, n_in, d_ff, d_in;
   logic [MW-1:0]        u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0]        k_ff, k_in, cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [MW:0]          rn_ff, rn_in, rd_ff, rd_in;
   logic [MW-1:0]        qn_ff, qn_in, qd_ff, qd_in;
   logic                 out_valid_ff, out_valid_in;
   logic [NUM_OUT_W-1:0] out_num_ff, out_num_in;
   logic [DEN_OUT_W-1:0] out_den_ff, out_den_in;
   logic [ERR_W-1:0]     out_err_ff, out_err_in;

   logic [ERR_W-1:0]       q_err;
   logic [MODE_W-1:0]      q_mode;
   logic signed [OW-1:0]   mul_a, mul_b;
   logic signed [2*OW-1:0] prod;
   logic signed [NW-1:0]   prod_x;
   logic signed [NW-1:0]   n_abs, d_abs;
   logic [MW:0]            tn, td;
   logic [XW-1:0]          ext_n, ext_d, sgn_n;

   assign q_err  = q_data[ENTRY_W-1 -: ERR_W];
   assign q_mode = q_data[ENTRY_W-ERR_W-1 -: MODE_W];

   // Shared multiplier: operand selection per product step.
   always_comb begin
      mul_a = na_ff;
      mul_b = db_ff;
      case (step_ff)
         2'd0: begin
            mul_a = na_ff;
            if (mode_ff == MODE_MUL) mul_b = nb_ff;
            else if (mode_ff == MODE_REDUCE) mul_b = OW'(1);
            else mul_b = db_ff;
         end
         2'd1: begin
            mul_a = nb_ff;
            mul_b = da_ff;
         end
         default: begin
            mul_a = da_ff;
            if (mode_ff == MODE_DIV) mul_b = nb_ff;
            else if (mode_ff == MODE_REDUCE) mul_b = OW'(1);
            else mul_b = db_ff;
         end
      endcase
      prod   = mul_a * mul_b;
      prod_x = {prod[2*OW-1], prod};
   end

   // Magnitudes, divider trial values and output formatting.
   always_comb begin
      n_abs = n_ff[NW-1] ? -n_ff : n_ff;
      d_abs = d_ff[NW-1] ? -d_ff : d_ff;
      tn    = {rn_ff[MW-1:0], qn_ff[MW-1]};
      td    = {rd_ff[MW-1:0], qd_ff[MW-1]};
      ext_n = XW'(qn_ff);
      ext_d = XW'(qd_ff);
      sgn_n = neg_ff ? -ext_n : ext_n;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      na_in        = na_ff;
      da_in        = da_ff;
      nb_in        = nb_ff;
      db_in        = db_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_err_in   = out_err_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_ctl.valid && !out_valid_ff) begin
               q_pop   = 1'b1;
               mode_in = q_mode;
               na_in   = q_data[4*OW-1 -: OW];
               da_in   = q_data[3*OW-1 -: OW];
               nb_in   = q_data[2*OW-1 -: OW];
               db_in   = q_data[OW-1:0];
               step_in = 2'd0;
               if (q_err != ERR_OK) begin
                  out_valid_in = 1'b1;
                  out_num_in   = '0;
                  out_den_in   = DEN_OUT_W'(1);
                  out_err_in   = q_err;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: n_in = prod_x;
               2'd1: begin
                  if (mode_ff == MODE_ADD) n_in = n_ff + prod_x;
                  else if (mode_ff == MODE_SUB) n_in = n_ff - prod_x;
               end
               default: begin
                  d_in     = prod_x;
                  state_in = ST_GCD;
               end
            endcase
         end
         ST_GCD: begin
            if (u_ff == '0) begin
               g_in     = v_ff << k_ff;
               rn_in    = '0;
               rd_in    = '0;
               qn_in    = n_abs[MW-1:0];
               qd_in    = d_abs[MW-1:0];
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         ST_DIV: begin
            if (tn >= {1'b0, g_ff}) begin
               rn_in = tn - {1'b0, g_ff};
               qn_in = {qn_ff[MW-2:0], 1'b1};
            end else begin
               rn_in = tn;
               qn_in = {qn_ff[MW-2:0], 1'b0};
            end
            if (td >= {1'b0, g_ff}) begin
               rd_in = td - {1'b0, g_ff};
               qd_in = {qd_ff[MW-2:0], 1'b1};
            end else begin
               rd_in = td;
               qd_in = {qd_ff[MW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(MW - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            out_valid_in = 1'b1;
            out_num_in   = sgn_n[NUM_OUT_W-1:0];
            out_den_in   = ext_d[DEN_OUT_W-1:0];
            out_err_in   = ERR_OK;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A zero numerator skips the reduction.
      if (state_ff == ST_MUL && step_ff == 2'd2) begin
         if (n_ff == '0) begin
            out_valid_in = 1'b1;
            out_num_in   = '0;
            out_den_in   = DEN_OUT_W'(1);
            out_err_in   = ERR_OK;
            state_in     = ST_IDLE;
         end
         u_in   = n_abs[MW-1:0];
         v_in   = prod_x[NW-1] ? MW'(-prod_x) : prod_x[MW-1:0];
         k_in   = '0;
         neg_in = n_ff[NW-1] ^ prod_x[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      mode_ff    <= mode_in;
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_result_num = out_num_ff;
   assign rsp_result_den = out_den_ff;
   assign rsp_error      = out_err_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact signed fraction arithmetic with reduction
// Adds, subtracts, multiplies or divides two fractions, or reduces the first,
// and returns the result in lowest terms with a positive denominator.
//
// Usage:
//   A request transfer on the req_ channel carries the mode and both
//   fractions. Each request gives exactly one transfer on the rsp_ channel,
//   in request order. The front end classifies a request and puts it in a
//   two-entry queue, so up to two requests are taken while the engine works.
//   Flow: a request with an error code goes straight from the queue to the
//   output register. Otherwise the engine forms the products on one shared
//   multiplier, then runs binary GCD steps (data dependent in number),
//   then divides both magnitudes in the shift-subtract divider and
//   registers the result. The engine takes no new request until it is
//   through with the last one, so requests are worked one at a time.
//   A zero numerator skips the reduction.
//   Reset empties the queue and drops any held result. While rsp_stall is
//   high the result stays in the output register; the engine starts no new
//   item until it is taken, and req_stall rises when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [MODE_W-1:0]        req_mode,
   input  wire logic [OPERAND_WIDTH-1:0] req_num_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_den_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_num_b,
   input  wire logic [OPERAND_WIDTH-1:0] req_den_b,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [NUM_OUT_W-1:0]     rsp_result_num,
   output logic      [DEN_OUT_W-1:0]     rsp_result_den,
   output logic      [ERR_W-1:0]         rsp_error
);

   localparam int ENTRY_W = ERR_W + MODE_W + 4 * OPERAND_WIDTH;

   logic [ENTRY_W-1:0] entry, q_data;
   logic               q_full, q_pop, push;
   queue_ctl_type      q_ctl;

   // Front end.
   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .mode  (req_mode),
      .num_a (req_num_a),
      .den_a (req_den_a),
      .num_b (req_num_b),
      .den_b (req_den_b),
      .entry (entry)
   );

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Queue between front and back end.
   rau_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .full      (q_full),
      .ctl_out   (q_ctl),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   // Back end.
   rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_ctl          (q_ctl),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_error      (rsp_error)
   );

   // An error result carries the fixed zero-over-one value.
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_OK |-> rsp_result_num == '0 && rsp_result_den == 1)
      else $error("error result not 0/1");

   // A good result never has a zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_OK |-> rsp_result_den != '0)
      else $error("zero denominator in result");

   // Reset drops any held result.
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Error codes stay in range.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error == ERR_OK || rsp_error == ERR_ZERO_DEN ||
                    rsp_error == ERR_DIV_ZERO)
      else $error("bad error code");

endmodule

`default_nettype wire
